// ===== sv/touch_sample_filter_defines.svh =====
// Assertion macros shared by the touch sample filter.
`ifndef TOUCH_SAMPLE_FILTER_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_DEFINES_SVH
`ifndef SYNTH
`define TSF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define TSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSF_ASSERT(label, clk, rst, prop)
`define TSF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/tsf_pkg.sv =====
// Types, constants and register codes of the touch sample filter.
`timescale 1ns / 1ps
package tsf_pkg;
   localparam int SAMPLE_W    = 12;
   localparam int PRESSURE_W  = 13;
   localparam int TIME_W      = 32;
   localparam int ROT_W       = 2;
   localparam int INTERVAL_W  = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 13;
   localparam int NUM_LANES   = 2;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 40;

   localparam logic [SAMPLE_W-1:0]   FULL_SCALE       = 12'd4095;
   localparam logic [TIME_W-1:0]     LAST_TOUCH_RESET = 32'h8000_0000;
   localparam logic [PRESSURE_W-1:0] THRESHOLD_RESET  = 13'd400;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 8'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL  = 8'd2;

   localparam logic [ROT_W-1:0] ROT_SWAP_MIRROR_X = 2'd0;
   localparam logic [ROT_W-1:0] ROT_NATIVE        = 2'd1;
   localparam logic [ROT_W-1:0] ROT_SWAP_MIRROR_Y = 2'd2;
   localparam logic [ROT_W-1:0] ROT_MIRROR_BOTH   = 2'd3;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [ROT_W-1:0]      rotation;
      logic [PRESSURE_W-1:0] threshold;
      logic [INTERVAL_W-1:0] interval;
   } cfg_type;

   typedef struct packed {
      logic [PRESSURE_W-1:0] pressure;
      sample_type            pos_y;
      sample_type            pos_x;
   } result_type;

   typedef struct packed {
      logic window_open;
      logic touch;
   } status_type;
endpackage

// ===== sv/touch_sample_filter.sv =====
// Each result is registered into a two-entry output buffer when its request is accepted,
// which lets requests flow while a result waits. Throughput: one sample set per cycle
// unless the buffer is full; the held state and last-touch time update on each accept.
// Reset is synchronous and active high: registers return to their reset values, the
// held position and pressure to zero, the last-touch time to 0x80000000, the buffer empty.
`timescale 1ns / 1ps
`include "touch_sample_filter_defines.svh"
module touch_sample_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // now_ms, pressure_one, pressure_two, x_first, x_second, x_third,
   // y_first, y_second, y_third
   input  logic [tsf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pos_x, pos_y, pressure, zero padding
   output logic [tsf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tsf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tsf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tsf_pkg::*;

   cfg_type              cfg_ff;
   sample_type           lane_a [NUM_LANES];
   sample_type           lane_b [NUM_LANES];
   sample_type           lane_c [NUM_LANES];
   sample_type           lane_mean [NUM_LANES];
   result_type           held;
   result_type           result;
   status_type           status;
   result_type           slot0_ff;
   result_type           slot1_ff;
   logic [1:0]           count_ff;
   logic                 push;
   logic                 pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation  <= ROT_SWAP_MIRROR_X;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.interval  <= INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ROTATION) begin
            cfg_ff.rotation <= csr_data[ROT_W-1:0];
         end
         if (csr_index == CSR_THRESHOLD) begin
            cfg_ff.threshold <= csr_data[PRESSURE_W-1:0];
         end
         if (csr_index == CSR_INTERVAL) begin
            cfg_ff.interval <= csr_data[INTERVAL_W-1:0];
         end
      end
   end

   assign lane_a[0] = req_tdata[67:56];
   assign lane_b[0] = req_tdata[79:68];
   assign lane_c[0] = req_tdata[91:80];
   assign lane_a[1] = req_tdata[103:92];
   assign lane_b[1] = req_tdata[115:104];
   assign lane_c[1] = req_tdata[127:116];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      tsf_lane u_lane (
         .sample_a (lane_a[i]),
         .sample_b (lane_b[i]),
         .sample_c (lane_c[i]),
         .mean     (lane_mean[i])
      );
   end

   assign push = req_tvalid && req_tready;
   assign pop  = rsp_tvalid && rsp_tready;

   tsf_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (push),
      .cfg          (cfg_ff),
      .now_ms       (req_tdata[31:0]),
      .pressure_one (req_tdata[43:32]),
      .pressure_two (req_tdata[55:44]),
      .x_mean       (lane_mean[0]),
      .y_mean       (lane_mean[1]),
      .held         (held),
      .result       (result),
      .status       (status)
   );

   assign req_tready = count_ff != 2'd2;
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {{(RSP_DATA_W-PRESSURE_W-2*SAMPLE_W){1'b0}},
                        slot0_ff.pressure, slot0_ff.pos_y, slot0_ff.pos_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         slot0_ff <= (push && count_ff == 2'd1) ? result : slot1_ff;
         if (push && count_ff == 2'd2) begin
            slot1_ff <= result;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= result;
         end else begin
            slot1_ff <= result;
         end
      end
   end

   `TSF_ASSERT(a_touch_implies_window, clock, reset, !status.touch || status.window_open)
   `TSF_ASSERT_NEXT(a_closed_window_holds, clock, reset, push && !status.window_open,
                    held == $past(held))
   `TSF_ASSERT_NEXT(a_pop_only_drains, clock, reset, pop && !push,
                    count_ff == $past(count_ff) - 2'd1)
endmodule

// ===== sv/tsf_lane.sv =====
// One axis lane: mean of the closest two of three samples.
`timescale 1ns / 1ps
module tsf_lane (
   input  tsf_pkg::sample_type sample_a,
   input  tsf_pkg::sample_type sample_b,
   input  tsf_pkg::sample_type sample_c,
   output tsf_pkg::sample_type mean
);
   import tsf_pkg::*;

   sample_type            dist_ab;
   sample_type            dist_ac;
   sample_type            dist_bc;
   logic [SAMPLE_W:0]     sum;

   assign dist_ab = (sample_a > sample_b) ? sample_a - sample_b : sample_b - sample_a;
   assign dist_ac = (sample_a > sample_c) ? sample_a - sample_c : sample_c - sample_a;
   assign dist_bc = (sample_b > sample_c) ? sample_b - sample_c : sample_c - sample_b;

   always_comb begin
      priority if (dist_ab <= dist_ac && dist_ab <= dist_bc) begin
         sum = {1'b0, sample_a} + {1'b0, sample_b};
      end else if (dist_ac <= dist_bc) begin
         sum = {1'b0, sample_a} + {1'b0, sample_c};
      end else begin
         sum = {1'b0, sample_b} + {1'b0, sample_c};
      end
   end

   assign mean = sum[SAMPLE_W:1];
endmodule

// ===== sv/tsf_merge.sv =====
// Merging stage: interval and pressure tests, rotation and the held state.
`timescale 1ns / 1ps
module tsf_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  tsf_pkg::cfg_type                      cfg,
   input  logic [tsf_pkg::TIME_W-1:0]            now_ms,
   input  tsf_pkg::sample_type                   pressure_one,
   input  tsf_pkg::sample_type                   pressure_two,
   input  tsf_pkg::sample_type                   x_mean,
   input  tsf_pkg::sample_type                   y_mean,
   output tsf_pkg::result_type                   held,
   output tsf_pkg::result_type                   result,
   output tsf_pkg::status_type                   status
);
   import tsf_pkg::*;

   logic [TIME_W-1:0]     last_touch_ff;
   logic [TIME_W-1:0]     last_touch_in;
   result_type            held_ff;
   result_type            held_in;
   logic [TIME_W-1:0]     gap;
   logic [PRESSURE_W-1:0] pressure;
   sample_type            rot_x;
   sample_type            rot_y;

   assign gap      = now_ms - last_touch_ff;
   assign pressure = {1'b0, pressure_one} + {1'b0, FULL_SCALE} - {1'b0, pressure_two};

   assign status.window_open = gap >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval};
   assign status.touch       = status.window_open && (pressure >= cfg.threshold);

   always_comb begin
      unique case (cfg.rotation)
         ROT_SWAP_MIRROR_X: begin
            rot_x = FULL_SCALE - y_mean;
            rot_y = x_mean;
         end
         ROT_NATIVE: begin
            rot_x = x_mean;
            rot_y = y_mean;
         end
         ROT_SWAP_MIRROR_Y: begin
            rot_x = y_mean;
            rot_y = FULL_SCALE - x_mean;
         end
         default: begin
            rot_x = FULL_SCALE - x_mean;
            rot_y = FULL_SCALE - y_mean;
         end
      endcase
   end

   always_comb begin
      held_in       = held_ff;
      last_touch_in = last_touch_ff;
      if (status.touch) begin
         held_in.pos_x    = rot_x;
         held_in.pos_y    = rot_y;
         held_in.pressure = pressure;
         last_touch_in    = now_ms;
      end else if (status.window_open) begin
         held_in.pressure = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         last_touch_ff <= LAST_TOUCH_RESET;
      end else if (accept) begin
         held_ff       <= held_in;
         last_touch_ff <= last_touch_in;
      end
   end

   assign held   = held_ff;
   assign result = held_in;
endmodule
